// ===== rtl/tkps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tkps_pkg
// Shared types, constants and helpers of the top-k peak selector.
// ----------------------------------------------------------------------------
package tkps_pkg;

  localparam int MAX_PEAKS = 16;
  localparam int IDX_W     = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int CNT_W     = $clog2(MAX_PEAKS + 1);

  localparam int COORD_W   = 10;
  localparam int ENERGY_W  = 15;
  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 5;
  localparam int DIM_W     = 11;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // register index, taken from paddr word address
  localparam logic [1:0] REG_PEAK_COUNT = 2'd0;
  localparam logic [1:0] REG_FRAME_ROWS = 2'd1;
  localparam logic [1:0] REG_FRAME_COLS = 2'd2;

  // input kinds carried in s_axis_tuser
  localparam logic OP_PIXEL     = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  localparam logic [COUNT_W-1:0] PEAK_COUNT_RST = COUNT_W'(16);
  localparam logic [DIM_W-1:0]   FRAME_ROWS_RST = DIM_W'(240);
  localparam logic [DIM_W-1:0]   FRAME_COLS_RST = DIM_W'(320);

  typedef struct packed {
    logic [COUNT_W-1:0] peak_count;
    logic [DIM_W-1:0]   frame_rows;
    logic [DIM_W-1:0]   frame_cols;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             last;
    logic             clear;
    logic [IDX_W-1:0] rank;
  } cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [CNT_W-1:0] total;
  } status_t;

  // zero acts as one, anything above the table depth as the depth
  function automatic logic [CNT_W-1:0] effective_count(input logic [COUNT_W-1:0] pc);
    logic [CNT_W-1:0] res;
    if (pc == '0) begin
      res = CNT_W'(1);
    end else if (int'(pc) > MAX_PEAKS) begin
      res = CNT_W'(MAX_PEAKS);
    end else begin
      res = CNT_W'(pc);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tkps_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tkps_cfg
// APB register file: peak count and frame dimensions.
// ----------------------------------------------------------------------------
module tkps_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tkps_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tkps_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tkps_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output tkps_pkg::cfg_t                     cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_count <= tkps_pkg::PEAK_COUNT_RST;
      cfg.frame_rows <= tkps_pkg::FRAME_ROWS_RST;
      cfg.frame_cols <= tkps_pkg::FRAME_COLS_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        tkps_pkg::REG_PEAK_COUNT: cfg.peak_count <= pwdata[tkps_pkg::COUNT_W-1:0];
        tkps_pkg::REG_FRAME_ROWS: cfg.frame_rows <= pwdata[tkps_pkg::DIM_W-1:0];
        tkps_pkg::REG_FRAME_COLS: cfg.frame_cols <= pwdata[tkps_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tkps_pkg::REG_PEAK_COUNT: prdata = tkps_pkg::PDATA_W'(cfg.peak_count);
      tkps_pkg::REG_FRAME_ROWS: prdata = tkps_pkg::PDATA_W'(cfg.frame_rows);
      tkps_pkg::REG_FRAME_COLS: prdata = tkps_pkg::PDATA_W'(cfg.frame_cols);
      default:                  prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tkps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tkps_ctrl
// Sequencer: takes pixel beats while idle, walks the ranks at frame end.
// ----------------------------------------------------------------------------
module tkps_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_op,
  input  wire logic [tkps_pkg::CNT_W-1:0]   cap,
  input  tkps_pkg::status_t                 status,
  output logic                              in_ready,
  output tkps_pkg::cmd_t                    cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                      state;
  logic [tkps_pkg::IDX_W-1:0]  rank;
  logic                        last_rank;

  assign in_ready  = (state == ST_IDLE);
  assign last_rank = (tkps_pkg::CNT_W'(rank) + tkps_pkg::CNT_W'(1)) == cap;

  always_comb begin
    cmd.load  = (state == ST_READ) && status.out_free;
    cmd.last  = last_rank;
    cmd.clear = cmd.load && last_rank;
    cmd.rank  = rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rank  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_op == tkps_pkg::OP_FRAME_END) begin
            state <= ST_READ;
            rank  <= '0;
          end
        end
        ST_READ: begin
          if (status.out_free) begin
            if (last_rank) begin
              state <= ST_IDLE;
            end else begin
              rank <= rank + tkps_pkg::IDX_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tkps_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tkps_dp
// Datapath: peak test, sorted insertion table and readout register.
// ----------------------------------------------------------------------------
module tkps_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  tkps_pkg::cfg_t                         cfg,
  input  wire logic [tkps_pkg::CNT_W-1:0]        cap,
  input  wire logic                              pix_accept,
  input  wire logic [tkps_pkg::IN_DATA_W-1:0]    in_data,
  input  tkps_pkg::cmd_t                         cmd,
  input  wire logic                              out_ready,
  output tkps_pkg::status_t                      status,
  output logic                                   out_valid,
  output logic      [tkps_pkg::OUT_DATA_W-1:0]   out_data,
  output logic                                   out_slot,
  output logic                                   out_last
);

  localparam int N = tkps_pkg::MAX_PEAKS;

  logic signed [tkps_pkg::SAMPLE_W-1:0] in_energy;
  logic signed [tkps_pkg::SAMPLE_W-1:0] in_lmax;
  logic        [tkps_pkg::COORD_W-1:0]  in_row;
  logic        [tkps_pkg::COORD_W-1:0]  in_col;
  logic                                 interior;
  logic                                 is_peak;

  // candidate stage
  logic                                 cand_valid;
  logic [tkps_pkg::ENERGY_W-1:0]        cand_energy;
  logic [tkps_pkg::COORD_W-1:0]         cand_row;
  logic [tkps_pkg::COORD_W-1:0]         cand_col;

  // sorted table, strongest first
  logic [tkps_pkg::ENERGY_W-1:0]        kept_energy [N];
  logic [tkps_pkg::COORD_W-1:0]         kept_row    [N];
  logic [tkps_pkg::COORD_W-1:0]         kept_col    [N];
  logic [tkps_pkg::CNT_W-1:0]           kept_total;

  logic [tkps_pkg::ENERGY_W-1:0]        energy_next [N];
  logic [tkps_pkg::COORD_W-1:0]         row_next    [N];
  logic [tkps_pkg::COORD_W-1:0]         col_next    [N];
  logic [tkps_pkg::CNT_W-1:0]           total_next;

  logic [N-1:0]                         valid_mask;
  logic [N-1:0]                         gt_mask;
  logic [N-1:0]                         eq_mask;
  logic                                 full;
  logic                                 do_insert;
  logic                                 slot_hit;

  assign in_energy = in_data[15:0];
  assign in_lmax   = in_data[31:16];
  assign in_row    = in_data[41:32];
  assign in_col    = in_data[51:42];

  assign interior = (in_row != '0) && (in_col != '0) &&
                    ({1'b0, in_row} + tkps_pkg::DIM_W'(1) < cfg.frame_rows) &&
                    ({1'b0, in_col} + tkps_pkg::DIM_W'(1) < cfg.frame_cols);
  assign is_peak = interior && !in_energy[tkps_pkg::SAMPLE_W-1] && (in_energy >= in_lmax);

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= pix_accept && is_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      cand_energy <= in_energy[tkps_pkg::ENERGY_W-1:0];
      cand_row    <= in_row;
      cand_col    <= in_col;
    end
  end

  // per-entry compare; gt_mask is a prefix since the table is sorted
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid_mask[i] = kept_total > tkps_pkg::CNT_W'(i);
      gt_mask[i]    = valid_mask[i] && (kept_energy[i] > cand_energy);
      eq_mask[i]    = valid_mask[i] && (kept_energy[i] == cand_energy);
    end
  end

  assign full       = kept_total >= cap;
  // a full table drops a peak no stronger than its weakest entry
  assign do_insert  = cand_valid && !(|eq_mask) && !(full && (gt_mask == valid_mask));
  assign total_next = full ? kept_total : kept_total + tkps_pkg::CNT_W'(1);

  always_comb begin
    energy_next[0] = gt_mask[0] ? kept_energy[0] : cand_energy;
    row_next[0]    = gt_mask[0] ? kept_row[0]    : cand_row;
    col_next[0]    = gt_mask[0] ? kept_col[0]    : cand_col;
    for (int i = 1; i < N; i++) begin
      if (gt_mask[i]) begin
        energy_next[i] = kept_energy[i];
        row_next[i]    = kept_row[i];
        col_next[i]    = kept_col[i];
      end else if (gt_mask[i-1]) begin
        energy_next[i] = cand_energy;
        row_next[i]    = cand_row;
        col_next[i]    = cand_col;
      end else begin
        energy_next[i] = kept_energy[i-1];
        row_next[i]    = kept_row[i-1];
        col_next[i]    = kept_col[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int i = 0; i < N; i++) begin
        kept_energy[i] <= energy_next[i];
        kept_row[i]    <= row_next[i];
        kept_col[i]    <= col_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_total <= '0;
    end else if (cmd.clear) begin
      kept_total <= '0;
    end else if (do_insert) begin
      kept_total <= total_next;
    end
  end

  // readout register
  assign slot_hit        = tkps_pkg::CNT_W'(cmd.rank) < kept_total;
  assign status.out_free = !out_valid || out_ready;
  assign status.total    = kept_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_slot <= slot_hit;
      out_last <= cmd.last;
      if (slot_hit) begin
        out_data <= {5'd0, kept_col[cmd.rank], kept_row[cmd.rank], kept_energy[cmd.rank]};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/top_k_peak_selector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_peak_selector
// Keeps the strongest peaks of a frame and reads them out at frame end.
// ----------------------------------------------------------------------------
// pixel beats: one per cycle while not reading out; a peak is registered as candidate, then inserted
// frame-end beat: one result beat per rank (effective peak count), one per
//   cycle when the sink keeps up; input is held off until the last rank loads
// the output register decouples the sink; pixels resume while it drains
// reset (sync, active high): table empty, peak_count 16, frame 240 x 320
module top_k_peak_selector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // energy[15:0], nbhd_max[31:16], row[41:32], col[51:42], zero pad
  input  wire logic [tkps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // peak_energy[14:0], peak_row[24:15], peak_col[34:25], zero pad
  output logic      [tkps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // slot_valid
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tkps_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [tkps_pkg::PDATA_W-1:0]      pwdata,
  output logic      [tkps_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready
);

  tkps_pkg::cfg_t               cfg;
  tkps_pkg::cmd_t               cmd;
  tkps_pkg::status_t            status;
  logic [tkps_pkg::CNT_W-1:0]   cap;
  logic                         pix_accept;

  assign cap        = tkps_pkg::effective_count(cfg.peak_count);
  assign pix_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == tkps_pkg::OP_PIXEL);

  tkps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tkps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .cap      (cap),
    .status   (status),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  tkps_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cap        (cap),
    .pix_accept (pix_accept),
    .in_data    (s_axis_tdata),
    .cmd        (cmd),
    .out_ready  (m_axis_tready),
    .status     (status),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata),
    .out_slot   (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  // table never holds more than its depth
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    status.total <= tkps_pkg::CNT_W'(tkps_pkg::MAX_PEAKS))
    else $error("peak table count above depth");

  // an empty rank carries an all-zero payload
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("empty rank with nonzero payload");

  // a frame-end beat starts a readout that holds off input
  a_frame_end_holds: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == tkps_pkg::OP_FRAME_END)
    |=> !s_axis_tready)
    else $error("input taken right after frame end");

endmodule
`default_nettype wire

// ===== bench/top_k_peak_selector_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_peak_selector_tb
// Drives pixel and frame-end beats into the peak selector, keeps its own
// sorted peak table to work out every ranked readout beat, and compares each
// output beat field by field. Covers border pixels, equal energies, full
// tables, tiny frames, out-of-range peak counts and a count lowered
// mid-frame, then random frames under random source and sink stalls.
// ----------------------------------------------------------------------------
module top_k_peak_selector_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 4;

  typedef struct packed {
    logic        op;
    logic [15:0] energy;
    logic [15:0] lmax;
    logic [9:0]  row;
    logic [9:0]  col;
  } pix_t;

  typedef struct packed {
    logic [14:0] energy;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        valid;
    logic        last;
  } rank_t;

  logic clk;
  logic rst = 1'b1;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // energy[15:0], nbhd_max[31:16], row[41:32], col[51:42], zero pad
  logic [tkps_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // operation
  logic                            s_axis_tuser  = tkps_pkg::OP_PIXEL;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // peak_energy[14:0], peak_row[24:15], peak_col[34:25], zero pad
  logic [tkps_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // slot_valid
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [tkps_pkg::PADDR_W-1:0]    paddr   = '0;
  logic [tkps_pkg::PDATA_W-1:0]    pwdata  = '0;
  logic [tkps_pkg::PDATA_W-1:0]    prdata;
  logic                            pready;

  top_k_peak_selector u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow of the block's registers and peak table
  logic [tkps_pkg::COUNT_W-1:0] cfg_peaks = tkps_pkg::PEAK_COUNT_RST;
  logic [tkps_pkg::DIM_W-1:0]   cfg_rows  = tkps_pkg::FRAME_ROWS_RST;
  logic [tkps_pkg::DIM_W-1:0]   cfg_cols  = tkps_pkg::FRAME_COLS_RST;
  logic [14:0]        tbl_energy [tkps_pkg::MAX_PEAKS];
  logic [9:0]         tbl_row    [tkps_pkg::MAX_PEAKS];
  logic [9:0]         tbl_col    [tkps_pkg::MAX_PEAKS];
  int unsigned        tbl_fill = 0;

  pix_t        src_q[$];
  rank_t       ranked_q[$];
  pix_t        cur_beat;
  rank_t       want_rank;
  int unsigned src_gap       = 0;
  int unsigned sink_hold     = 0;
  int unsigned idle_pct      = 20;
  bit          long_hold_req = 1'b0;
  int unsigned err_count     = 0;
  int unsigned stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned ranks_in_use();
    if (cfg_peaks == '0) return 1;
    if (int'(cfg_peaks) > tkps_pkg::MAX_PEAKS) return tkps_pkg::MAX_PEAKS;
    return int'(cfg_peaks);
  endfunction

  function automatic void insert_peak(logic [14:0] e, logic [9:0] r, logic [9:0] c);
    int unsigned cap;
    int unsigned pos;
    cap = ranks_in_use();
    for (int i = 0; i < tbl_fill; i++)
      if (tbl_energy[i] == e) return;
    // full table: only a stronger peak gets in, and it evicts the weakest
    if (tbl_fill >= cap) begin
      if (tbl_fill == 0 || e <= tbl_energy[tbl_fill-1]) return;
      tbl_fill--;
    end
    if (tbl_fill >= tkps_pkg::MAX_PEAKS) return;
    pos = 0;
    while (pos < tbl_fill && tbl_energy[pos] > e) pos++;
    for (int i = tbl_fill; i > pos; i--) begin
      tbl_energy[i] = tbl_energy[i-1];
      tbl_row[i]    = tbl_row[i-1];
      tbl_col[i]    = tbl_col[i-1];
    end
    tbl_energy[pos] = e;
    tbl_row[pos]    = r;
    tbl_col[pos]    = c;
    tbl_fill++;
  endfunction

  function automatic void peak_table_step(pix_t it);
    int unsigned n;
    bit          interior;
    rank_t       rk;
    if (it.op == tkps_pkg::OP_PIXEL) begin
      interior = it.row >= 1 && int'(it.row) + 1 < int'(cfg_rows) &&
                 it.col >= 1 && int'(it.col) + 1 < int'(cfg_cols);
      if (interior && $signed(it.energy) >= 0 && $signed(it.energy) >= $signed(it.lmax))
        insert_peak(it.energy[14:0], it.row, it.col);
    end else begin
      n = ranks_in_use();
      for (int k = 0; k < n; k++) begin
        if (k < tbl_fill) begin
          rk.energy = tbl_energy[k];
          rk.row    = tbl_row[k];
          rk.col    = tbl_col[k];
          rk.valid  = 1'b1;
        end else begin
          rk.energy = '0;
          rk.row    = '0;
          rk.col    = '0;
          rk.valid  = 1'b0;
        end
        rk.last = (k + 1 == n);
        ranked_q.push_back(rk);
      end
      tbl_fill = 0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  function automatic pix_t pixel(int e, int m, int r, int c);
    pix_t p;
    p.op     = tkps_pkg::OP_PIXEL;
    p.energy = 16'(e);
    p.lmax   = 16'(m);
    p.row    = 10'(r);
    p.col    = 10'(c);
    return p;
  endfunction

  function automatic pix_t frame_end();
    pix_t p;
    p        = pixel($urandom, $urandom, $urandom, $urandom);
    p.op     = tkps_pkg::OP_FRAME_END;
    return p;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    int   rmax;
    int   cmax;
    int   e;
    int   d;
    rmax = (cfg_rows > 1024) ? 1023 : ((cfg_rows == 0) ? 0 : int'(cfg_rows) - 1);
    cmax = (cfg_cols > 1024) ? 1023 : ((cfg_cols == 0) ? 0 : int'(cfg_cols) - 1);
    if ($urandom_range(0, 9) == 0) begin
      p = pixel($urandom, $urandom, $urandom, $urandom);
    end else begin
      // small energies make equal-energy collisions common
      e = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32767))
                                      : int'($urandom_range(0, 63));
      d = int'($urandom_range(0, 5)) - 4;
      p = pixel(e, e + d, $urandom_range(0, rmax), $urandom_range(0, cmax));
    end
    return p;
  endfunction

  task automatic push_frame(int unsigned n_pix, bit with_end);
    repeat (n_pix) src_q.push_back(rand_pixel());
    if (with_end) src_q.push_back(frame_end());
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tkps_pkg::REG_PEAK_COUNT: cfg_peaks = val[tkps_pkg::COUNT_W-1:0];
      tkps_pkg::REG_FRAME_ROWS: cfg_rows  = val[tkps_pkg::DIM_W-1:0];
      default:                  cfg_cols  = val[tkps_pkg::DIM_W-1:0];
    endcase
  endtask

  // all beats sent, all readouts seen, then let the last insertion land
  task automatic drain_and_settle();
    while (!(src_q.size() == 0 && !s_axis_tvalid && ranked_q.size() == 0))
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) peak_table_step(cur_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (src_q.size() > 0) begin
          cur_beat = src_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, cur_beat.col, cur_beat.row, cur_beat.lmax, cur_beat.energy};
          s_axis_tuser  <= cur_beat.op;
          if ($urandom_range(0, 99) < idle_pct) src_gap = $urandom_range(1, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (ranked_q.size() == 0) begin
          $error("result beat with nothing pending: tdata 0x%0h", m_axis_tdata);
          err_count++;
        end else begin
          want_rank = ranked_q.pop_front();
          check_field("peak_energy", 32'(want_rank.energy), 32'(m_axis_tdata[14:0]));
          check_field("peak_row", 32'(want_rank.row), 32'(m_axis_tdata[24:15]));
          check_field("peak_col", 32'(want_rank.col), 32'(m_axis_tdata[34:25]));
          check_field("slot_valid", 32'(want_rank.valid), 32'(m_axis_tuser));
          check_field("last", 32'(want_rank.last), 32'(m_axis_tlast));
        end
      end
      if (long_hold_req) begin
        sink_hold     = LONG_HOLD;
        long_hold_req = 1'b0;
      end else if (sink_hold == 0 && $urandom_range(0, 99) < idle_pct) begin
        sink_hold = $urandom_range(1, 15);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // no beat moving while work is outstanding
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (src_q.size() == 0 && !s_axis_tvalid && ranked_q.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("top_k_peak_selector_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned n_random;
    int unsigned phase_no;
    int unsigned n_pix;
    n_random = 0;
    phase_no = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset config: extremes, sign, border and equal-energy cases
    src_q.push_back(pixel(32767, -32768, 1, 1));
    src_q.push_back(pixel(0, 0, 238, 318));
    src_q.push_back(pixel(-1, -32768, 5, 5));
    src_q.push_back(pixel(100, 101, 6, 6));
    src_q.push_back(pixel(100, 100, 7, 7));
    src_q.push_back(pixel(100, 0, 8, 8));
    src_q.push_back(pixel(500, 0, 0, 10));
    src_q.push_back(pixel(500, 0, 239, 10));
    src_q.push_back(pixel(500, 0, 1023, 1023));
    src_q.push_back(frame_end());
    src_q.push_back(frame_end());
    drain_and_settle();

    // single rank on a 3 x 3 frame: one interior pixel
    reg_write(tkps_pkg::REG_PEAK_COUNT, 1);
    reg_write(tkps_pkg::REG_FRAME_ROWS, 3);
    reg_write(tkps_pkg::REG_FRAME_COLS, 3);
    src_q.push_back(pixel(5, 0, 1, 1));
    src_q.push_back(pixel(7, 0, 1, 1));
    src_q.push_back(pixel(3, 0, 1, 1));
    src_q.push_back(pixel(9, 0, 2, 1));
    src_q.push_back(frame_end());
    drain_and_settle();

    // count zero acts as one, frame too short to have an interior
    reg_write(tkps_pkg::REG_PEAK_COUNT, 0);
    reg_write(tkps_pkg::REG_FRAME_ROWS, 2);
    reg_write(tkps_pkg::REG_FRAME_COLS, 2047);
    src_q.push_back(pixel(9, 0, 1, 1));
    src_q.push_back(frame_end());
    drain_and_settle();

    // count above depth, then lowered with the table part filled
    reg_write(tkps_pkg::REG_PEAK_COUNT, 31);
    reg_write(tkps_pkg::REG_FRAME_ROWS, 1024);
    reg_write(tkps_pkg::REG_FRAME_COLS, 1024);
    src_q.push_back(pixel(20, 0, 1022, 1022));
    src_q.push_back(pixel(30, 0, 1023, 5));
    src_q.push_back(pixel(10, 0, 3, 3));
    src_q.push_back(pixel(15, 0, 4, 4));
    drain_and_settle();
    reg_write(tkps_pkg::REG_PEAK_COUNT, 2);
    src_q.push_back(pixel(12, 0, 5, 5));
    src_q.push_back(frame_end());
    drain_and_settle();

    while (n_random < 110) begin
      if ($urandom_range(0, 1))
        reg_write(tkps_pkg::REG_PEAK_COUNT, ($urandom_range(0, 7) == 0) ?
                  (($urandom_range(0, 1) == 1) ? 0 : $urandom_range(17, 31)) :
                  $urandom_range(1, 16));
      if ($urandom_range(0, 1))
        reg_write(tkps_pkg::REG_FRAME_ROWS, ($urandom_range(0, 5) == 0) ?
                  $urandom_range(0, 2047) : $urandom_range(3, 24));
      if ($urandom_range(0, 1))
        reg_write(tkps_pkg::REG_FRAME_COLS, ($urandom_range(0, 5) == 0) ?
                  $urandom_range(0, 2047) : $urandom_range(3, 24));
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (phase_no == 3) begin
        // sink stalls long while frame ends keep coming
        reg_write(tkps_pkg::REG_PEAK_COUNT, 16);
        long_hold_req = 1'b1;
        push_frame(6, 1'b1);
        push_frame(6, 1'b1);
        push_frame(10, 1'b1);
        n_random += 25;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          n_pix = $urandom_range(3, 20);
          push_frame(n_pix, $urandom_range(0, 3) != 0);
          n_random += n_pix + 1;
        end
      end
      drain_and_settle();
      phase_no++;
    end

    idle_pct = 0;
    push_frame(20, 1'b1);
    drain_and_settle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("top_k_peak_selector_tb: done, clean");
    end else begin
      $display("top_k_peak_selector_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/tkps_pkg.sv
rtl/tkps_cfg.sv
rtl/tkps_ctrl.sv
rtl/tkps_dp.sv
rtl/top_k_peak_selector.sv
bench/top_k_peak_selector_tb.sv
